/* sv/ukt_pkg.sv */
// Shared widths, operation codes and defaults for the unordered key table.
package ukt_pkg;

  localparam int unsigned FuncW  = 2;
  localparam int unsigned ValueW = 32;
  localparam int unsigned FillW  = 7;
  localparam int unsigned CapW   = 7;

  localparam int unsigned DefDepth = 64;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  // operation codes carried in the func field; code 3 is unused
  localparam logic [FuncW-1:0] FuncInsert = 2'd0;
  localparam logic [FuncW-1:0] FuncRemove = 2'd1;
  localparam logic [FuncW-1:0] FuncSearch = 2'd2;

endpackage

/* sv/ukt_if.sv */
// Valid/ready channel interfaces for the key table's request and response beats.
interface ukt_in_if;
  logic                              valid;
  logic                              ready;
  logic [ukt_pkg::FuncW-1:0]         func;
  logic signed [ukt_pkg::ValueW-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface ukt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic                       found;
  logic [ukt_pkg::FillW-1:0]  fill;

  modport source (output valid, output ok, output found, output fill, input ready);
  modport sink   (input valid, input ok, input found, input fill, output ready);
endinterface

/* sv/unordered_key_table.sv */
// Sequence: insert and unused codes go straight to StDone and the output register;
// remove/search on a filled table take one read (StRead) and one compare (StCmp)
// per scanned entry; a remove hit then swaps in the last entry (StLast, StMove).
// Throughput: one beat at a time; the entry memory's single read port and its one
// comparator are reused for every scanned slot. A finished response may wait in
// the output register while the next request is taken. Reset clears the count.
module unordered_key_table #(
  parameter int unsigned DEPTH = ukt_pkg::DefDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ukt_pkg::CapW-1:0] cfg_wdata_i,
  ukt_in_if.sink                   in_i,
  ukt_out_if.source                out_o
);

  // count must hold DEPTH itself; the address only indexes stored slots
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // common width for comparing the count with the capacity register and DEPTH
  localparam int unsigned WideW = (CntW > ukt_pkg::CapW) ? CntW : ukt_pkg::CapW;
  localparam logic [WideW-1:0] DepthW = WideW'(DEPTH);

  typedef enum logic [2:0] {
    StIdle,   // waiting for a request beat
    StRead,   // memory read of slot idx_q
    StCmp,    // compare read data with the key
    StLast,   // remove hit: read the last filled slot
    StMove,   // write the last entry into the hit slot, shrink count
    StDone    // response ready, waiting for the output register
  } state_e;

  state_e                        state_q;
  logic [CntW-1:0]               count_q;
  logic [CntW-1:0]               idx_q;
  logic [ukt_pkg::CapW-1:0]      cap_q;
  logic [ukt_pkg::FuncW-1:0]     func_q;
  logic signed [ukt_pkg::ValueW-1:0] key_q;
  logic                          res_ok_q;
  logic                          res_found_q;
  logic                          out_valid_q;
  logic                          out_ok_q;
  logic                          out_found_q;
  logic [ukt_pkg::FillW-1:0]     out_fill_q;

  // entry memory, one port each way
  logic signed [ukt_pkg::ValueW-1:0] mem_q [DEPTH];
  logic signed [ukt_pkg::ValueW-1:0] rdata_q;
  logic                              mem_we;
  logic [AddrW-1:0]                  mem_wa;
  logic signed [ukt_pkg::ValueW-1:0] mem_wd;
  logic                              mem_re;
  logic [AddrW-1:0]                  mem_ra;

  logic            in_acc;
  logic            room;
  logic            hit;
  logic            scan_end;
  logic            out_free;
  logic [CntW-1:0] last_idx;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;

  // insert needs count below both the capacity register and the built depth
  assign room     = (WideW'(count_q) < WideW'(cap_q)) && (WideW'(count_q) < DepthW);
  assign hit      = (rdata_q == key_q);
  assign scan_end = ((idx_q + CntW'(1)) == count_q);
  assign out_free = !out_valid_q || out_o.ready;
  assign last_idx = count_q - CntW'(1);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = count_q[AddrW-1:0];
    mem_wd = in_i.value;
    if (in_acc && (in_i.func == ukt_pkg::FuncInsert) && room) begin
      mem_we = 1'b1;
    end else if (state_q == StMove) begin
      mem_we = 1'b1;
      mem_wa = idx_q[AddrW-1:0];
      mem_wd = rdata_q;
    end
  end

  assign mem_re = (state_q == StRead) || (state_q == StLast);
  assign mem_ra = (state_q == StLast) ? last_idx[AddrW-1:0] : idx_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      cap_q       <= ukt_pkg::CapReset;
      func_q      <= ukt_pkg::FuncInsert;
      key_q       <= '0;
      res_ok_q    <= 1'b0;
      res_found_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_found_q <= 1'b0;
      out_fill_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end

      // in StDone the output register is reloaded below instead
      if (out_valid_q && out_o.ready && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            func_q      <= in_i.func;
            key_q       <= in_i.value;
            idx_q       <= '0;
            res_ok_q    <= 1'b0;
            res_found_q <= 1'b0;
            state_q     <= StDone;
            if (in_i.func == ukt_pkg::FuncInsert) begin
              if (room) begin
                count_q  <= count_q + CntW'(1);
                res_ok_q <= 1'b1;
              end
            end else if ((in_i.func == ukt_pkg::FuncRemove) ||
                         (in_i.func == ukt_pkg::FuncSearch)) begin
              if (count_q != '0) begin
                state_q <= StRead;
              end
            end
          end
        end
        StRead: begin
          state_q <= StCmp;
        end
        StCmp: begin
          if (hit) begin
            res_found_q <= 1'b1;
            res_ok_q    <= 1'b1;
            state_q     <= (func_q == ukt_pkg::FuncRemove) ? StLast : StDone;
          end else if (scan_end) begin
            // no match; a remove on a filled table still reports ok
            res_ok_q <= (func_q == ukt_pkg::FuncRemove);
            state_q  <= StDone;
          end else begin
            idx_q   <= idx_q + CntW'(1);
            state_q <= StRead;
          end
        end
        StLast: begin
          state_q <= StMove;
        end
        StMove: begin
          count_q <= last_idx;
          state_q <= StDone;
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ok_q    <= res_ok_q;
            out_found_q <= res_found_q;
            out_fill_q  <= ukt_pkg::FillW'(count_q);
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.ok    = out_ok_q;
  assign out_o.found = out_found_q;
  assign out_o.fill  = out_fill_q;

endmodule
